// ===== src/wwsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwsa_pkg
// Shared types and constants of the wide word stack ALU.
// ----------------------------------------------------------------------------
package wwsa_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned LANE_W          = 64;
  localparam int unsigned LANES           = 4;
  localparam int unsigned WORD_W          = LANE_W * LANES;
  localparam int unsigned MODE_W          = 3;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DEPTH_OUT_W     = 5;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_STORE = 3'd1,
    OP_POP   = 3'd2,
    OP_ADD   = 3'd3,
    OP_SUB   = 3'd4,
    OP_DUP   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage : wwsa_pkg
`default_nettype wire

// ===== src/wwsa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwsa_ram
// Word store below the top of stack: one write and one registered read port.
// ----------------------------------------------------------------------------
module wwsa_ram
  import wwsa_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire word_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output word_t              rd_data
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : wwsa_ram
`default_nettype wire

// ===== src/wwsa_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wwsa_alu
// 256-bit add or subtract, modulo 2^256: top plus next, or top minus next.
// ----------------------------------------------------------------------------
module wwsa_alu
  import wwsa_pkg::*;
(
  input  wire word_t top,
  input  wire word_t nxt,
  input  wire logic  sub,
  output word_t      result
);

  always_comb begin
    if (sub) begin
      result = top - nxt;
    end else begin
      result = top + nxt;
    end
  end

endmodule : wwsa_alu
`default_nettype wire

// ===== src/wide_word_stack_alu_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wide_word_stack_alu_top
// Stack of 256-bit words with push, store, pop, add, sub and dup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one instruction per beat: mode
//   and the four 64-bit lanes of the word to push. Output channel
//   (out_valid/out_ready) returns one beat per instruction: the top word after
//   the operation (zero when empty), a status (ok, underflow, overflow) and
//   the depth.
//   The top word lives in a register; the entries below it sit in a RAM with
//   a registered read. On acceptance the entry under the top is read into
//   that read register; once the output register is free the operation
//   completes, writes back and loads the output register. A new item is
//   taken only after the previous item has loaded its result.
//   Reset empties the stack (depth zero) and drops any pending result; RAM
//   contents are not cleared and need no clearing pass.
//   When the receiver stalls, the result holds in the output register; the
//   next item is still accepted and then waits to execute until that
//   register is free.
// ----------------------------------------------------------------------------
module wide_word_stack_alu_top
  import wwsa_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [MODE_W-1:0]      mode,
  input  wire logic [LANE_W-1:0]      in_lane_0,
  input  wire logic [LANE_W-1:0]      in_lane_1,
  input  wire logic [LANE_W-1:0]      in_lane_2,
  input  wire logic [LANE_W-1:0]      in_lane_3,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LANE_W-1:0]           out_lane_0,
  output logic [LANE_W-1:0]           out_lane_1,
  output logic [LANE_W-1:0]           out_lane_2,
  output logic [LANE_W-1:0]           out_lane_3,
  output logic [STATUS_W-1:0]         status,
  output logic [DEPTH_OUT_W-1:0]      stack_depth
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  word_t           top_word;
  word_t           top_next;
  logic [MODE_W-1:0] mode_q;
  word_t           push_word;

  logic            in_fire;
  logic            out_free;
  logic            exec_fire;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  word_t           rd_data;
  word_t           alu_result;
  status_t         res_status;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rd_addr  = AW'(count - CW'(2));
  assign wr_addr  = AW'(count - CW'(1));

  wwsa_ram #(
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_word),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wwsa_alu u_alu (
    .top    (top_word),
    .nxt    (rd_data),
    .sub    (mode_q == OP_SUB),
    .result (alu_result)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = (state == S_IDLE);
    exec_fire = (state == S_EXEC) && out_free;
  end

  // Operation decode against the current stack
  always_comb begin
    top_next   = top_word;
    count_next = count;
    wr_en      = 1'b0;
    res_status = ST_OK;
    unique case (mode_q)
      OP_PUSH: begin
        if (count == FULL) begin
          res_status = ST_OVER;
        end else begin
          wr_en      = (count != '0);
          top_next   = push_word;
          count_next = count + CW'(1);
        end
      end
      OP_STORE: begin
        if (count == '0) res_status = ST_UNDER;
      end
      OP_POP: begin
        if (count == '0) begin
          res_status = ST_UNDER;
        end else begin
          top_next   = rd_data;
          count_next = count - CW'(1);
        end
      end
      OP_ADD, OP_SUB: begin
        if (count < CW'(2)) begin
          res_status = ST_UNDER;
        end else begin
          top_next   = alu_result;
          count_next = count - CW'(1);
        end
      end
      OP_DUP: begin
        if (count == '0) begin
          res_status = ST_UNDER;
        end else if (count == FULL) begin
          res_status = ST_OVER;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      default: ;
    endcase
    wr_en = wr_en && exec_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (exec_fire) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q    <= mode;
      push_word <= {in_lane_3, in_lane_2, in_lane_1, in_lane_0};
    end
    if (exec_fire) begin
      top_word <= top_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      if (count_next == '0) begin
        {out_lane_3, out_lane_2, out_lane_1, out_lane_0} <= '0;
      end else begin
        {out_lane_3, out_lane_2, out_lane_1, out_lane_0} <= top_next;
      end
      status      <= res_status;
      stack_depth <= DEPTH_OUT_W'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_depth_bound : assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("stack count beyond depth");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> (count == $past(count) + 1'b1 || count == $past(count) - 1'b1))
    else $error("stack count moved by more than one");

  a_exec_result : assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> out_valid)
    else $error("executed item gave no result");

  a_no_write_full : assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count != '0 && count != FULL))
    else $error("store write outside live range");
`endif

endmodule : wide_word_stack_alu_top
`default_nettype wire
